// ===== hdl/b64_pkg.sv =====
// Shared types, constants and alphabet functions for the Base64 codec.
// No dependencies; every other file of the codec imports this package.
`timescale 1ns / 1ps

package b64_pkg;

  // Depth of the queue between front and back.
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTRW  = $clog2(QDEPTH);
  localparam int unsigned QCNTW  = $clog2(QDEPTH + 1);

  // Result status codes.
  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_LEN = 2'd1;
  localparam logic [1:0] ST_BAD = 2'd2;

  // Mode register values.
  localparam logic MODE_ENC = 1'b0;
  localparam logic MODE_DEC = 1'b1;

  localparam logic [7:0] PAD_CHAR = 8'h3D;
  localparam logic [6:0] BAD_SYM  = 7'd64;

  // One group worth of results, handed from front to back.
  typedef struct packed {
    logic [3:0][7:0] bytes;     // results in delivery order
    logic [1:0]      last_idx;  // index of the final result
    logic [1:0]      status;
    logic            msg_end;   // group closes the message
  } job_t;

  // Six-bit value to alphabet character.
  function automatic logic [7:0] sym_char(input logic [5:0] v);
    logic [7:0] w;
    w = {2'b00, v};
    if (v < 6'd26)      return w + 8'h41;
    else if (v < 6'd52) return w + 8'd71;
    else if (v < 6'd62) return w - 8'd4;
    else if (v == 6'd62) return 8'h2B;
    else                 return 8'h2F;
  endfunction

  // Alphabet character to value; unknown characters give BAD_SYM.
  function automatic logic [6:0] char_sym(input logic [7:0] c);
    if (c >= 8'h41 && c <= 8'h5A)      return 7'(c - 8'h41);
    else if (c >= 8'h61 && c <= 8'h7A) return 7'(c - 8'd71);
    else if (c >= 8'h30 && c <= 8'h39) return 7'(c + 8'd4);
    else if (c == 8'h2B)               return 7'd62;
    else if (c == 8'h2F)               return 7'd63;
    else                               return BAD_SYM;
  endfunction

endpackage

// ===== hdl/base64_codec_core.sv =====
// Streaming Base64 encoder/decoder, top level: mode register, front end,
// job queue and back end. Uses b64_pkg, b64_front, b64_queue, b64_back.
// A beat that closes a group is pushed into the job queue, then read out through the back end output register.
// Throughput: one result per cycle from the back end output register while
// out_ready holds; the front end takes one beat per cycle while the job queue has room.
// Reset (synchronous) selects encode and empties the group, queue and output.
`timescale 1ns / 1ps

module base64_codec_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       mode,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       message_end,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       run_last,
  output logic       message_done,
  output logic [1:0] status
);
  import b64_pkg::*;

  logic mode_reg;
  logic cfg_we;
  logic push_valid;
  job_t push_job;
  logic q_full;
  logic pop;
  logic head_valid;
  job_t head_job;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  // Mode register.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg <= MODE_ENC;
    end else if (cfg_we) begin
      mode_reg <= mode;
    end
  end

  b64_front u_front (
    .clk         (clk),
    .rst         (rst),
    .mode        (mode_reg),
    .cfg_we      (cfg_we),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_byte     (in_byte),
    .message_end (message_end),
    .q_full      (q_full),
    .push_valid  (push_valid),
    .push_job    (push_job)
  );

  b64_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_job   (push_job),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  b64_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head_job     (head_job),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .run_last     (run_last),
    .message_done (message_done),
    .status       (status)
  );

`ifndef SYNTHESIS
  // The end of a message always closes the run of its input beat.
  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && message_done |-> run_last)
    else $error("message_done without run_last");

  // A length error is a lone zero result that ends the message.
  a_len_err_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_LEN |-> out_byte == 8'h00 && run_last && message_done)
    else $error("malformed length error result");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");
`endif

endmodule

// ===== hdl/b64_front.sv =====
// Front end of the Base64 codec: accepts input beats, gathers groups and
// turns each finished group into a job for the back end. Uses b64_pkg.
`timescale 1ns / 1ps

module b64_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               mode,
  input  logic               cfg_we,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_byte,
  input  logic               message_end,
  input  logic               q_full,
  output logic               push_valid,
  output b64_pkg::job_t      push_job
);
  import b64_pkg::*;

  logic [23:0] group_bits, group_bits_next;
  logic [1:0]  group_count, group_count_next;
  logic [1:0]  pad_seen, pad_seen_next;
  logic        bad_char_seen, bad_char_seen_next;

  logic        accept;
  logic        emit;
  logic [1:0]  pos;
  logic [23:0] byte_shift;
  logic [23:0] sym_shift;
  logic [23:0] bits_new;
  logic [6:0]  sym;
  logic [1:0]  pad_new;
  logic        bad_new;
  job_t        job;

  assign in_ready   = !q_full;
  assign accept     = in_valid && in_ready;
  assign push_valid = accept && emit;
  assign push_job   = job;

  // Gather the beat into the group and build the job when the group closes.
  always_comb begin
    pos        = 2'd0;
    byte_shift = '0;
    sym_shift  = '0;
    sym        = char_sym(in_byte);
    bits_new   = group_bits;
    pad_new    = pad_seen;
    bad_new    = bad_char_seen;
    emit       = 1'b0;
    job        = '0;
    if (mode == MODE_ENC) begin
      pos = (group_count == 2'd3) ? 2'd0 : group_count;
      unique case (pos)
        2'd0:    byte_shift = {in_byte, 16'h0000};
        2'd1:    byte_shift = {8'h00, in_byte, 8'h00};
        default: byte_shift = {16'h0000, in_byte};
      endcase
      bits_new = group_bits | byte_shift;
      emit     = (pos == 2'd2) || message_end;
      // A short group is padded with '=' past its last real character.
      job.bytes[0] = sym_char(bits_new[23:18]);
      job.bytes[1] = sym_char(bits_new[17:12]);
      job.bytes[2] = (pos != 2'd0) ? sym_char(bits_new[11:6]) : PAD_CHAR;
      job.bytes[3] = (pos == 2'd2) ? sym_char(bits_new[5:0]) : PAD_CHAR;
      job.last_idx = 2'd3;
      job.status   = ST_OK;
    end else begin
      pos = group_count;
      unique case (pos)
        2'd0:    sym_shift = {sym[5:0], 18'h00000};
        2'd1:    sym_shift = {5'h00, sym, 12'h000};
        2'd2:    sym_shift = {11'h000, sym, 6'h00};
        default: sym_shift = {17'h00000, sym};
      endcase
      // A pad only counts in the last two places; elsewhere it is unknown.
      if (in_byte == PAD_CHAR && pos[1]) begin
        pad_new[pos[0]] = 1'b1;
      end else if (sym == BAD_SYM) begin
        bad_new = 1'b1;
      end
      bits_new = group_bits | sym_shift;
      emit     = (pos == 2'd3) || message_end;
      if (pos == 2'd3) begin
        job.bytes[0] = bits_new[23:16];
        job.bytes[1] = pad_new[0] ? bits_new[7:0] : bits_new[15:8];
        job.bytes[2] = bits_new[7:0];
        job.last_idx = 2'({1'b0, !pad_new[0]}) + 2'({1'b0, !pad_new[1]});
        job.status   = bad_new ? ST_BAD : ST_OK;
      end else begin
        job.last_idx = 2'd0;
        job.status   = ST_LEN;
      end
    end
    job.msg_end = message_end;
  end

  // Next group state: cleared when a group closes or the mode is written.
  always_comb begin
    group_bits_next    = group_bits;
    group_count_next   = group_count;
    pad_seen_next      = pad_seen;
    bad_char_seen_next = bad_char_seen;
    if (cfg_we) begin
      group_bits_next    = '0;
      group_count_next   = '0;
      pad_seen_next      = '0;
      bad_char_seen_next = 1'b0;
    end else if (accept) begin
      if (emit) begin
        group_bits_next    = '0;
        group_count_next   = '0;
        pad_seen_next      = '0;
        bad_char_seen_next = 1'b0;
      end else begin
        group_bits_next    = bits_new;
        group_count_next   = pos + 2'd1;
        pad_seen_next      = pad_new;
        bad_char_seen_next = bad_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      group_bits    <= '0;
      group_count   <= '0;
      pad_seen      <= '0;
      bad_char_seen <= 1'b0;
    end else begin
      group_bits    <= group_bits_next;
      group_count   <= group_count_next;
      pad_seen      <= pad_seen_next;
      bad_char_seen <= bad_char_seen_next;
    end
  end

endmodule

// ===== hdl/b64_queue.sv =====
// Short job queue between the front and back ends of the Base64 codec.
// Register based, QDEPTH entries; uses b64_pkg for the job type.
`timescale 1ns / 1ps

module b64_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push_valid,
  input  b64_pkg::job_t      push_job,
  output logic               full,
  input  logic               pop,
  output logic               head_valid,
  output b64_pkg::job_t      head_job
);
  import b64_pkg::*;

  job_t             entries [QDEPTH];
  logic [QPTRW-1:0] wr_ptr, wr_ptr_next;
  logic [QPTRW-1:0] rd_ptr, rd_ptr_next;
  logic [QCNTW-1:0] count, count_next;
  logic             do_push;
  logic             do_pop;

  assign full       = (count == QCNTW'(QDEPTH));
  assign head_valid = (count != '0);
  assign head_job   = entries[rd_ptr];
  assign do_push    = push_valid && !full;
  assign do_pop     = pop && head_valid;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_next = wr_ptr;
    rd_ptr_next = rd_ptr;
    count_next  = count;
    if (do_push) begin
      wr_ptr_next = (wr_ptr == QPTRW'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_next = (rd_ptr == QPTRW'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_next = count + 1'b1;
    end else if (do_pop && !do_push) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  // Job storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

endmodule

// ===== hdl/b64_back.sv =====
// Back end of the Base64 codec: walks the head job one result a cycle into
// the output register while the output is taken. Uses b64_pkg for the job type.
`timescale 1ns / 1ps

module b64_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               head_valid,
  input  b64_pkg::job_t      head_job,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_byte,
  output logic               run_last,
  output logic               message_done,
  output logic [1:0]         status
);
  import b64_pkg::*;

  logic [1:0] idx, idx_next;
  logic       out_valid_next;
  logic       load;
  logic       is_last;

  assign load    = head_valid && (!out_valid || out_ready);
  assign is_last = (idx == head_job.last_idx);
  assign pop     = load && is_last;

  // Result index and output valid.
  always_comb begin
    idx_next       = idx;
    out_valid_next = out_valid;
    if (load) begin
      idx_next       = is_last ? 2'd0 : idx + 2'd1;
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      idx       <= idx_next;
      out_valid <= out_valid_next;
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (load) begin
      out_byte     <= head_job.bytes[idx];
      run_last     <= is_last;
      message_done <= is_last && head_job.msg_end;
      status       <= head_job.status;
    end
  end

endmodule

// ===== tb/tb_base64_codec_core.sv =====
// Self-checking testbench for base64_codec_core: encode and decode streams.
// The predictor, driver and monitor are in this file; it depends only on b64_pkg and the RTL.
`timescale 1ns / 1ps

module tb_base64_codec_core;
  import b64_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 400000;
  localparam int unsigned HOLD_CYCLES  = 150;

  // One input beat waiting to be offered, and one result beat owed by the block.
  typedef struct packed {
    logic [7:0] data;
    logic       fin;
  } in_item_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       done;
    logic [1:0] st;
  } out_item_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       mode = MODE_ENC;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte = 8'h00;
  logic       message_end = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic       run_last;
  logic       message_done;
  logic [1:0] status;

  in_item_t    send_q[$];
  out_item_t   out_due[$];
  in_item_t    nxt_item;
  out_item_t   got;

  // Predictor state.
  logic        cur_mode;
  logic [23:0] grp_bits;
  int unsigned grp_cnt;
  logic [1:0]  pad_flags;
  logic        bad_flag;

  logic        in_took = 1'b0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned hold_cnt = 0;
  logic        hold_served = 1'b0;
  logic        hold_req = 1'b0;
  logic        send_idle_en = 1'b0;
  logic        recv_idle_en = 1'b0;

  int unsigned cycle_cnt = 0;
  int unsigned n_err = 0;
  int unsigned n_queued = 0;
  int unsigned n_in = 0;
  int unsigned n_out = 0;
  int unsigned n_cfg = 0;
  int unsigned n_len_err = 0;
  int unsigned n_bad = 0;

  base64_codec_core u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .mode         (mode),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_byte      (in_byte),
    .message_end  (message_end),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .run_last     (run_last),
    .message_done (message_done),
    .status       (status)
  );

  always #1 clk = ~clk;

  // Six-bit value to its alphabet character.
  function automatic logic [7:0] letter(input logic [5:0] s);
    if (s < 6'd26) return 8'h41 + 8'(s);
    if (s < 6'd52) return 8'h61 + 8'(s - 6'd26);
    if (s < 6'd62) return 8'h30 + 8'(s - 6'd52);
    return (s == 6'd62) ? 8'h2B : 8'h2F;
  endfunction

  // Alphabet character to its value; anything else maps to BAD_SYM.
  function automatic logic [6:0] sym_of(input logic [7:0] c);
    if (c >= 8'h41 && c <= 8'h5A) return 7'(c - 8'h41);
    if (c >= 8'h61 && c <= 8'h7A) return 7'(c - 8'h61 + 8'd26);
    if (c >= 8'h30 && c <= 8'h39) return 7'(c - 8'h30 + 8'd52);
    if (c == 8'h2B) return 7'd62;
    if (c == 8'h2F) return 7'd63;
    return BAD_SYM;
  endfunction

  // Mostly short idle stretches, now and then a long one.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 8);
    return $urandom_range(15, 40);
  endfunction

  task automatic clear_group();
    grp_bits  = '0;
    grp_cnt   = 0;
    pad_flags = '0;
    bad_flag  = 1'b0;
  endtask

  task automatic owe(input logic [7:0] d, input logic [1:0] st, inout out_item_t burst[$]);
    out_item_t b;
    b.data = d;
    b.last = 1'b0;
    b.done = 1'b0;
    b.st   = st;
    burst.push_back(b);
  endtask

  // Advance the codec state by one accepted input beat and queue its results.
  task automatic codec_step(input logic [7:0] c, input logic fin);
    out_item_t   burst[$];
    out_item_t   b;
    int unsigned p;
    logic [6:0]  v;
    logic [1:0]  st;
    p = grp_cnt;
    if (cur_mode == MODE_ENC) begin
      if (p > 2) p = 0;
      grp_bits = grp_bits | (24'(c) << ((2 - p) * 8));
      p++;
      // A full group, or a short one at message end, gives four characters.
      if (p == 3 || fin) begin
        for (int k = 0; k < 4; k++) begin
          owe((k <= p) ? letter(6'(grp_bits >> ((3 - k) * 6))) : PAD_CHAR, ST_OK, burst);
        end
        clear_group();
      end else begin
        grp_cnt = p;
      end
    end else begin
      v = sym_of(c);
      // A pad only counts as one in the third or fourth position.
      if (c == PAD_CHAR && p >= 2) pad_flags[p - 2] = 1'b1;
      else if (v == BAD_SYM) bad_flag = 1'b1;
      grp_bits = 24'((32'(v) << ((3 - p) * 6)) | 32'(grp_bits));
      p++;
      if (p == 4) begin
        st = bad_flag ? ST_BAD : ST_OK;
        if (bad_flag) n_bad++;
        owe(grp_bits[23:16], st, burst);
        if (!pad_flags[0]) owe(grp_bits[15:8], st, burst);
        if (!pad_flags[1]) owe(grp_bits[7:0], st, burst);
        clear_group();
      end else if (fin) begin
        // The message stopped inside a group.
        owe(8'h00, ST_LEN, burst);
        n_len_err++;
        clear_group();
      end else begin
        grp_cnt = p;
      end
    end
    if (burst.size() != 0) begin
      b = burst.pop_back();
      b.last = 1'b1;
      b.done = fin;
      burst.push_back(b);
    end
    foreach (burst[i]) out_due.push_back(burst[i]);
  endtask

  // Predict on accepted beats, check result beats, and watch the clock budget.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles with %0d results still owed.", cycle_cnt,
               out_due.size());
      $display("*** FAILED ***");
      $finish;
    end
    if (rst) begin
      in_took <= 1'b0;
      cur_mode = MODE_ENC;
      clear_group();
    end else begin
      in_took <= in_valid && in_ready;
      if (cfg_valid && cfg_ready) begin
        cur_mode = mode;
        clear_group();
        n_cfg++;
      end
      if (in_valid && in_ready) begin
        codec_step(in_byte, message_end);
        n_in++;
      end
      if (out_valid && out_ready) begin
        n_out++;
        if (out_due.size() == 0) begin
          $error("result beat with nothing owed: out_byte=%02h status=%0d", out_byte, status);
          n_err++;
        end else begin
          got = out_due.pop_front();
          if (out_byte !== got.data) begin
            $error("out_byte: expected %02h, got %02h", got.data, out_byte);
            n_err++;
          end
          if (run_last !== got.last) begin
            $error("run_last: expected %0b, got %0b", got.last, run_last);
            n_err++;
          end
          if (message_done !== got.done) begin
            $error("message_done: expected %0b, got %0b", got.done, message_done);
            n_err++;
          end
          if (status !== got.st) begin
            $error("status: expected %0d, got %0d", got.st, status);
            n_err++;
          end
        end
      end
    end
  end

  // Sender: offers queued beats, holding each until taken, with random gaps.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else if (in_valid && !in_took) begin
      // Beat still on offer; keep it steady.
    end else if (gap_left != 0) begin
      in_valid <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (send_q.size() != 0) begin
      nxt_item = send_q.pop_front();
      in_valid    <= 1'b1;
      in_byte     <= nxt_item.data;
      message_end <= nxt_item.fin;
      gap_left <= (send_idle_en && $urandom_range(0, 99) < 30) ? idle_len() : 0;
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Receiver: random stalls, plus one long hold-off that backs the block up.
  always @(negedge clk) begin
    if (rst) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else if (hold_req && !hold_served) begin
      out_ready <= 1'b0;
      if (hold_cnt == HOLD_CYCLES) hold_served <= 1'b1;
      else hold_cnt <= hold_cnt + 1;
    end else if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (recv_idle_en && $urandom_range(0, 99) < 25) begin
      out_ready  <= 1'b0;
      stall_left <= idle_len() - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic push_item(input logic [7:0] d, input logic fin);
    in_item_t it;
    it.data = d;
    it.fin  = fin;
    send_q.push_back(it);
    n_queued++;
  endtask

  // Wait until every queued beat is taken and every owed result has come out.
  task automatic settle();
    while (send_q.size() != 0 || in_valid || out_due.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_mode(input logic m);
    @(negedge clk);
    cfg_valid <= 1'b1;
    mode      <= m;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // A raw byte message, mostly short so every tail length comes up often.
  task automatic add_enc_msg();
    int unsigned len;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 7);
    for (int i = 0; i < len; i++) push_item(8'($urandom), i == len - 1);
  endtask

  // A well-formed character message, sometimes damaged on purpose.
  task automatic add_dec_msg();
    logic [7:0]  chars[$];
    logic [23:0] raw;
    int unsigned ngrp;
    int unsigned tail;
    int unsigned r;
    int unsigned cut;
    ngrp = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 8) : $urandom_range(1, 3);
    for (int g = 0; g < ngrp; g++) begin
      raw  = 24'($urandom);
      tail = (g == ngrp - 1) ? $urandom_range(1, 3) : 3;
      for (int j = 0; j < 4; j++) chars.push_back(letter(6'(raw >> (18 - 6 * j))));
      if (tail < 3) chars[chars.size() - 1] = PAD_CHAR;
      if (tail < 2) chars[chars.size() - 2] = PAD_CHAR;
    end
    r = $urandom_range(0, 99);
    if (r < 10) begin
      // Any byte value in a random spot.
      chars[$urandom_range(0, chars.size() - 1)] = 8'($urandom);
    end else if (r < 15) begin
      // Pad too early in some group.
      chars[4 * $urandom_range(0, ngrp - 1) + $urandom_range(0, 1)] = PAD_CHAR;
    end else if (r < 20) begin
      // Pad in the third position followed by a real character.
      chars[chars.size() - 2] = PAD_CHAR;
      chars[chars.size() - 1] = letter(6'($urandom));
    end else if (r < 28) begin
      // Message ends inside a group.
      cut = $urandom_range(1, 3);
      repeat (cut) void'(chars.pop_back());
    end
    foreach (chars[i]) push_item(chars[i], i == chars.size() - 1);
  endtask

  // One phase: set the mode, pick the idling, then queue random messages.
  task automatic run_phase(input logic m, input int unsigned target, input logic s_idle,
                           input logic r_idle);
    int unsigned start;
    settle();
    write_mode(m);
    send_idle_en = s_idle;
    recv_idle_en = r_idle;
    start = n_queued;
    while (n_queued - start < target) begin
      if (m == MODE_DEC) add_dec_msg();
      else add_enc_msg();
    end
    // Sometimes leave a partial group for the next mode write to drop.
    if ($urandom_range(0, 2) == 0) begin
      repeat ($urandom_range(1, 2)) push_item(8'($urandom), 1'b0);
    end
  endtask

  initial begin
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    // Directed encode: two-byte and one-byte tails, a full group plus a tail,
    // then a partial group that the next mode write discards.
    push_item(8'h00, 1'b0);
    push_item(8'hFF, 1'b1);
    push_item(8'hFF, 1'b1);
    push_item(8'h80, 1'b0);
    push_item(8'h01, 1'b0);
    push_item(8'hFE, 1'b0);
    push_item(8'h7F, 1'b1);
    push_item(8'h41, 1'b0);
    push_item(8'h42, 1'b0);
    settle();
    write_mode(MODE_DEC);

    // Directed decode: top alphabet values, double pad, pad at third only,
    // early pad with an unknown character, and a short message.
    push_item(8'h2F, 1'b0);
    push_item(8'h2F, 1'b0);
    push_item(8'h2B, 1'b0);
    push_item(8'h2F, 1'b0);
    push_item(8'h54, 1'b0);
    push_item(8'h51, 1'b0);
    push_item(PAD_CHAR, 1'b0);
    push_item(PAD_CHAR, 1'b1);
    push_item(8'h54, 1'b0);
    push_item(8'h57, 1'b0);
    push_item(PAD_CHAR, 1'b0);
    push_item(8'h75, 1'b1);
    push_item(PAD_CHAR, 1'b0);
    push_item(8'h41, 1'b0);
    push_item(8'h2A, 1'b0);
    push_item(PAD_CHAR, 1'b1);
    push_item(8'h39, 1'b0);
    push_item(8'h7A, 1'b1);

    run_phase(MODE_ENC, 45, 1'b1, 1'b1);
    run_phase(MODE_DEC, 55, 1'b1, 1'b1);

    // Back-pressure: the receiver stops for a long stretch while beats keep coming.
    settle();
    hold_req = 1'b1;
    run_phase(MODE_ENC, 30, 1'b0, 1'b1);
    run_phase(MODE_DEC, 35, 1'b0, 1'b0);
    run_phase(MODE_DEC, 25, 1'b1, 1'b1);
    run_phase(MODE_ENC, 15, 1'b0, 1'b0);
    settle();

    $display("Covered %0d input beats and %0d result beats across %0d mode writes.",
             n_in, n_out, n_cfg);
    $display("Decode saw %0d groups with bad characters and %0d short messages.",
             n_bad, n_len_err);
    if (n_err == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
